[hdl/atrm_pkg.sv]
// Shared types, constants and helpers for the AT response matcher.
`timescale 1ns / 1ps
package atrm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] MAX_PATTERN = 5'd16;
    localparam logic [8:0] MAX_REPLY   = 9'd256;
    localparam logic [7:0] CR_CHAR     = 8'h0D;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_LO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_HI     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd7;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_MATCH   = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic       valid;
        logic [7:0] rbyte;
        logic [7:0] index;
    } t_result;

    function automatic logic [7:0] pick_char(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [3:0] pos);
        logic [63:0] w;
        w = pos[3] ? hi : lo;
        return w[{pos[2:0], 3'b000} +: 8];
    endfunction

endpackage

[hdl/atrm_front.sv]
// Front end: classifies incoming transactions and queues them for the matcher.
`timescale 1ns / 1ps
module atrm_front import atrm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_req_valid,
    output t_req       o_req,
    input  logic       i_req_take
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;
    t_req             w_item;

    always_comb begin
        case (i_cmd)
            CMD_START: w_item.op = OP_START;
            CMD_BYTE:  w_item.op = OP_BYTE;
            CMD_TICK:  w_item.op = OP_TICK;
            default:   w_item.op = OP_NONE;
        endcase
        w_item.data = i_rx_byte;
    end

    assign full        = (r_cnt == CNT_W'(DEPTH));
    assign w_wr        = push && !full;
    assign o_req_valid = (r_cnt != '0);
    assign w_rd        = i_req_take && o_req_valid;
    assign o_req       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_wr) - CNT_W'(w_rd);
        end
    end

endmodule

[hdl/atrm_back.sv]
// Back end: configuration registers, prompt/terminator matcher and result queue.
`timescale 1ns / 1ps
module atrm_back import atrm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  t_req                 i_req,
    output logic                 o_req_take,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        PH_PROMPT = 2'd0,
        PH_GATHER = 2'd1,
        PH_TERM   = 2'd2
    } t_phase;

    logic [63:0] r_prompt_lo, r_prompt_hi, r_term_lo, r_term_hi;
    logic [4:0]  r_prompt_len, r_term_len;
    logic [8:0]  r_capacity;
    logic [31:0] r_timeout;

    t_phase      r_phase, n_phase;
    t_status     r_status, n_status;
    logic [4:0]  r_ppos, n_ppos, r_tpos, n_tpos;
    logic [8:0]  r_room, n_room;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_ticks, n_ticks;
    t_result     n_res;

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_deq;

    logic [4:0]  w_plen, w_tlen, w_ppos_inc, w_tpos_inc;
    logic [8:0]  w_cap;
    logic [31:0] w_ticks_inc;
    logic [7:0]  w_c;

    assign w_deq       = pop && !empty;
    assign empty       = (r_cnt == '0);
    assign o_req_take  = i_req_valid && ((r_cnt != CNT_W'(DEPTH)) || w_deq);
    assign o_cfg_ready = 1'b1;
    assign o_result    = r_mem[r_rd_ptr];

    assign w_c         = i_req.data;
    assign w_plen      = (r_prompt_len > MAX_PATTERN) ? MAX_PATTERN : r_prompt_len;
    assign w_tlen      = (r_term_len > MAX_PATTERN) ? MAX_PATTERN :
                         (r_term_len == 5'd0) ? 5'd1 : r_term_len;
    assign w_cap       = (r_capacity > MAX_REPLY) ? MAX_REPLY : r_capacity;
    assign w_ppos_inc  = r_ppos + 5'd1;
    assign w_tpos_inc  = r_tpos + 5'd1;
    assign w_ticks_inc = r_ticks + 32'd1;

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_ppos   = r_ppos;
        n_tpos   = r_tpos;
        n_room   = r_room;
        n_count  = r_count;
        n_ticks  = r_ticks;
        n_res.valid = 1'b0;
        n_res.rbyte = 8'd0;
        n_res.index = 8'd0;
        case (i_req.op)
            OP_START: begin
                n_ppos   = 5'd0;
                n_tpos   = 5'd0;
                n_phase  = (r_prompt_len != 5'd0) ? PH_PROMPT : PH_TERM;
                n_room   = w_cap;
                n_count  = 8'd0;
                n_ticks  = 32'd0;
                n_status = (r_timeout == 32'd0) ? ST_TIMEOUT : ST_WAIT;
            end
            OP_BYTE: begin
                if (r_status == ST_WAIT) begin
                    if (r_phase == PH_PROMPT) begin
                        if (w_c == pick_char(r_prompt_lo, r_prompt_hi, r_ppos[3:0])) begin
                            n_ppos = w_ppos_inc;
                            if (w_ppos_inc >= w_plen) begin
                                n_phase = PH_GATHER;
                            end
                        end else begin
                            n_ppos = (w_c == pick_char(r_prompt_lo, r_prompt_hi, 4'd0))
                                     ? 5'd1 : 5'd0;
                        end
                    end else if (r_phase == PH_GATHER) begin
                        if (r_room != 9'd0) begin
                            if (w_c == CR_CHAR || r_room < 9'd2) begin
                                n_phase = PH_TERM;
                            end else begin
                                n_res.valid = 1'b1;
                                n_res.rbyte = w_c;
                                n_res.index = r_count;
                                n_count     = r_count + 8'd1;
                                n_room      = r_room - 9'd1;
                            end
                        end
                    end
                    if (w_c == pick_char(r_term_lo, r_term_hi, r_tpos[3:0])) begin
                        n_tpos = w_tpos_inc;
                        if (w_tpos_inc >= w_tlen) begin
                            n_status = ST_MATCH;
                        end
                    end else begin
                        n_tpos = (w_c == pick_char(r_term_lo, r_term_hi, 4'd0)) ? 5'd1 : 5'd0;
                    end
                end
            end
            OP_TICK: begin
                if (r_status == ST_WAIT) begin
                    n_ticks = w_ticks_inc;
                    if (w_ticks_inc >= r_timeout) begin
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_mem[r_wr_ptr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prompt_lo  <= 64'd0;
            r_prompt_hi  <= 64'd0;
            r_prompt_len <= 5'd0;
            r_term_lo    <= 64'h0A4B;
            r_term_hi    <= 64'd0;
            r_term_len   <= 5'd2;
            r_capacity   <= 9'd0;
            r_timeout    <= 32'd2000;
            r_phase      <= PH_TERM;
            r_status     <= ST_IDLE;
            r_ppos       <= 5'd0;
            r_tpos       <= 5'd0;
            r_room       <= 9'd0;
            r_count      <= 8'd0;
            r_ticks      <= 32'd0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PROMPT_LO:  r_prompt_lo  <= i_cfg_data;
                    CFG_PROMPT_HI:  r_prompt_hi  <= i_cfg_data;
                    CFG_PROMPT_LEN: r_prompt_len <= i_cfg_data[4:0];
                    CFG_TERM_LO:    r_term_lo    <= i_cfg_data;
                    CFG_TERM_HI:    r_term_hi    <= i_cfg_data;
                    CFG_TERM_LEN:   r_term_len   <= i_cfg_data[4:0];
                    CFG_CAPACITY:   r_capacity   <= i_cfg_data[8:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (o_req_take) begin
                r_phase  <= n_phase;
                r_status <= n_status;
                r_ppos   <= n_ppos;
                r_tpos   <= n_tpos;
                r_room   <= n_room;
                r_count  <= n_count;
                r_ticks  <= n_ticks;
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(o_req_take) - CNT_W'(w_deq);
        end
    end

endmodule

[hdl/at_response_matcher.sv]
// Top level of the AT response matcher: input queue, matcher and result queue.
// A push is registered in the input queue; its result is registered in the result queue.
// One transaction (one compare-and-update) per cycle while the result queue can take it.
// Queues of DEPTH entries on both sides let producer and consumer stall independently.
// Reset (synchronous, active low): queues empty, matcher not armed, registers at defaults.
`timescale 1ns / 1ps
module at_response_matcher import atrm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_wait_status,
    output logic                 o_reply_valid,
    output logic [7:0]           o_reply_byte,
    output logic [7:0]           o_reply_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic    w_req_valid, w_req_take;
    t_req    w_req;
    t_result w_result;

    atrm_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_take  (w_req_take)
    );

    atrm_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_take  (w_req_take),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_result    (w_result)
    );

    assign o_wait_status = w_result.status;
    assign o_reply_valid = w_result.valid;
    assign o_reply_byte  = w_result.rbyte;
    assign o_reply_index = w_result.index;

    a_result_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && $past(empty)) |-> $past(w_req_take))
        else $error("result appeared without a processed transaction");

    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_reply_valid) |-> (o_reply_byte == 8'd0 && o_reply_index == 8'd0))
        else $error("reply fields nonzero without a stored character");

    a_full_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !$past(full)) |-> $past(push))
        else $error("input queue filled without a push");

    a_reply_needs_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_reply_valid) |-> (o_wait_status == ST_WAIT || o_wait_status == ST_MATCH))
        else $error("reply character stored outside a running wait");

endmodule
